// File: sv/crcfr_pkg.sv
// Shared types, codes and CRC-32C helpers for the CRC-32C frame receiver.
package crcfr_pkg;

	localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
	localparam int          HDR_BYTES    = 9;
	localparam int          CRC_BYTES    = 4;

	// frame status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_OVERSIZED   = 3'd3;
	localparam logic [2:0] ST_CRC_MISM    = 3'd4;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_MAX_LEN = 2'd2;

	// commands from the parser to the CRC/result engine
	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_PAYLOAD  = 3'd1,
		OP_CRC      = 3'd2,
		OP_CRC_LAST = 3'd3,
		OP_STATUS   = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] payload_byte;
		logic [2:0] frame_status;
	} res_t;

	typedef struct packed {
		logic [31:0] expected_magic;
		logic [7:0]  expected_version;
		logic [31:0] max_payload_bytes;
	} cfg_t;

	// reflected CRC-32C table entry; constant logic for each index
	function automatic logic [31:0] crc_tab(input logic [7:0] idx);
		logic [31:0] c;
		c = {24'd0, idx};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		return (crc >> 8) ^ crc_tab(crc[7:0] ^ b);
	endfunction

endpackage

// File: sv/crc32c_frame_receiver.sv
// Top level of the CRC-32C length-prefixed frame receiver.
//
// Usage: feed the received stream one byte per item on rx_byte with push; an
// item is taken at a clock edge where push is high and full is low. Results
// come out like a queue: while empty is low the oldest result sits on
// out_kind/payload_byte/frame_status and is taken with pop. out_kind 0 is a
// forwarded payload byte, out_kind 1 a frame status that ends the frame.
// Configuration (magic, version, max length) is written through cfg_wr,
// cfg_addr, cfg_wdata while no frame is in flight; index 3 is ignored.
// Throughput: one byte per cycle sustained while the consumer keeps up. The
// parser takes a byte each cycle into a command queue, and the CRC engine
// does one table step per command per cycle. Path: the edge that accepts a
// byte loads the command queue, and the engine then moves its result into
// the result queue once that queue has room. Early CRC bytes and header
// bytes give no result, except the last byte of a rejected header.
// Reset clears the queues, returns the parser to header hunting, and loads
// the register defaults. When the consumer stalls, the result queue fills,
// the engine holds, the command queue fills and full rises to hold the sender.
module crc32c_frame_receiver
	import crcfr_pkg::*;
#(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        out_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  frame_status,
	input  logic        cfg_wr,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	cfg_t cfg_q;
	logic accept;
	logic cmd_push, cmd_full, cmd_empty, cmd_pop;
	cmd_t cmd_in, cmd_out;
	logic res_push, res_full;
	res_t res_in, res_out;

	// configuration registers; a write lands at once and the parser uses it
	// at the next header check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_magic    <= 32'd0;
			cfg_q.expected_version  <= 8'd1;
			cfg_q.max_payload_bytes <= 32'd65536;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_MAGIC:   cfg_q.expected_magic    <= cfg_wdata;
				REG_VERSION: cfg_q.expected_version  <= cfg_wdata[7:0];
				REG_MAX_LEN: cfg_q.max_payload_bytes <= cfg_wdata;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	// take a byte whenever the command queue has room
	assign full   = cmd_full;
	assign accept = push & ~cmd_full;

	crcfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	crcfr_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	crcfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue decouples the engine from the consumer
	crcfr_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign out_kind     = res_out.out_kind;
	assign payload_byte = res_out.payload_byte;
	assign frame_status = res_out.frame_status;

endmodule

// File: sv/crcfr_fifo.sv
// Small register FIFO used between parser and engine and at the result side.
module crcfr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/crcfr_front.sv
// Frame parser: tracks header, payload and CRC phases and issues engine commands.
module crcfr_front
	import crcfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       cmd_push,
	output cmd_t       cmd
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_CRC     = 2'd2;

	localparam logic [31:0] HDR_LAST = 32'(HDR_BYTES - 1);
	localparam logic [1:0]  CRC_LAST = 2'(CRC_BYTES - 1);

	logic [1:0]  phase_q, phase_d;
	logic [31:0] pos_q, pos_d, pos_inc;
	logic [31:0] magic_q, magic_d;
	logic [7:0]  ver_q, ver_d;
	logic [31:0] len_q, len_d;

	assign pos_inc = pos_q + 32'd1;

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		magic_d  = magic_q;
		ver_d    = ver_q;
		len_d    = len_q;
		cmd_push = 1'b0;
		cmd.op   = OP_PAYLOAD;
		cmd.data = rx_byte;
		if (accept) begin
			case (phase_q)
				PH_PAYLOAD: begin
					cmd_push = 1'b1;
					pos_d    = pos_inc;
					if (pos_inc >= len_q) begin
						phase_d = PH_CRC;
						pos_d   = '0;
					end
				end
				PH_CRC: begin
					cmd_push = 1'b1;
					if (pos_q[1:0] == CRC_LAST) begin
						cmd.op  = OP_CRC_LAST;
						phase_d = PH_HEADER;
						pos_d   = '0;
					end else begin
						cmd.op = OP_CRC;
						pos_d  = pos_inc;
					end
				end
				default: begin
					// header bytes: magic, version, then length, all big-endian
					if (pos_q < 32'd4) begin
						magic_d = {magic_q[23:0], rx_byte};
					end else if (pos_q == 32'd4) begin
						ver_d = rx_byte;
					end else begin
						len_d = {len_q[23:0], rx_byte};
					end
					pos_d = pos_inc;
					if (pos_q == HDR_LAST) begin
						pos_d    = '0;
						cmd_push = 1'b1;
						cmd.op   = OP_STATUS;
						phase_d  = PH_HEADER;
						if (magic_d != cfg.expected_magic) begin
							cmd.data = {5'd0, ST_BAD_MAGIC};
						end else if (ver_d != cfg.expected_version) begin
							cmd.data = {5'd0, ST_BAD_VERSION};
						end else if (len_d > cfg.max_payload_bytes) begin
							cmd.data = {5'd0, ST_OVERSIZED};
						end else begin
							cmd.op  = OP_START;
							phase_d = (len_d == '0) ? PH_CRC : PH_PAYLOAD;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		magic_q <= magic_d;
		ver_q   <= ver_d;
		len_q   <= len_d;
	end

endmodule

// File: sv/crcfr_back.sv
// CRC engine: runs CRC-32C over payload, collects the received CRC, builds results.
module crcfr_back
	import crcfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	logic [31:0] crc_q, rcv_q, rcv_new;

	assign cmd_pop = ~cmd_empty & ~res_full;
	assign rcv_new = {rcv_q[23:0], cmd.data};

	always_comb begin
		res_push         = 1'b0;
		res.out_kind     = KIND_STATUS;
		res.payload_byte = '0;
		res.frame_status = ST_OK;
		if (cmd_pop) begin
			case (cmd.op)
				OP_PAYLOAD: begin
					res_push         = 1'b1;
					res.out_kind     = KIND_PAYLOAD;
					res.payload_byte = cmd.data;
				end
				OP_CRC_LAST: begin
					res_push         = 1'b1;
					res.frame_status = ((~crc_q) == rcv_new) ? ST_OK : ST_CRC_MISM;
				end
				OP_STATUS: begin
					res_push         = 1'b1;
					res.frame_status = cmd.data[2:0];
				end
				default: begin
					res_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			rcv_q <= '0;
		end else if (cmd_pop) begin
			case (cmd.op)
				OP_START: begin
					crc_q <= CRC_INIT;
					rcv_q <= '0;
				end
				OP_PAYLOAD: begin
					crc_q <= crc_step(crc_q, cmd.data);
				end
				OP_CRC, OP_CRC_LAST: begin
					rcv_q <= rcv_new;
				end
				default: begin
					crc_q <= crc_q;
				end
			endcase
		end
	end

endmodule

// File: bench/tb.sv
// Self-checking testbench for the CRC-32C length-prefixed frame receiver.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crcfr_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;  // index past the last register, must be ignored
	localparam int SETTLE_CYCLES = 8;          // drain margin kept after the last owed result
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {HUNT_HEADER, IN_PAYLOAD, IN_CRC} rx_phase_t;

	// One directed byte; rows marked typed carry a status read straight off the frame
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic [2:0] status;
	} dir_row_t;

	localparam dir_row_t DIRECTED_ROWS [22] = '{
		// zero-length frame under reset config: magic 0, version 1, length 0,
		// then the CRC of an empty payload, which is all zeros
		'{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
		'{8'h00, 1'b0, ST_OK}, '{8'h01, 1'b0, ST_OK},
		'{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
		'{8'h00, 1'b0, ST_OK},
		'{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK}, '{8'h00, 1'b0, ST_OK},
		'{8'h00, 1'b1, ST_OK},
		// all-ones header: magic check fails first, ahead of version and length
		'{8'hFF, 1'b0, ST_OK}, '{8'hFF, 1'b0, ST_OK}, '{8'hFF, 1'b0, ST_OK},
		'{8'hFF, 1'b0, ST_OK}, '{8'hFF, 1'b0, ST_OK}, '{8'hFF, 1'b0, ST_OK},
		'{8'hFF, 1'b0, ST_OK}, '{8'hFF, 1'b0, ST_OK},
		'{8'hFF, 1'b1, ST_BAD_MAGIC}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic        out_kind;
	logic [7:0]  payload_byte;
	logic [2:0]  frame_status;
	logic        cfg_wr = 1'b0;
	logic [1:0]  cfg_addr = 2'd0;
	logic [31:0] cfg_wdata = 32'd0;

	// Shadow of the receiver: configuration and parse state
	logic [31:0] want_magic = 32'd0;
	logic [7:0]  want_version = 8'd1;
	logic [31:0] len_limit = 32'd65536;
	rx_phase_t   rx_phase = HUNT_HEADER;
	logic [31:0] pos_cnt = 32'd0;
	logic [31:0] magic_acc = 32'd0;
	logic [7:0]  version_acc = 8'd0;
	logic [31:0] length_acc = 32'd0;
	logic [31:0] crc_acc = CRC_INIT;
	logic [31:0] crc_rx = 32'd0;

	res_t awaited[$];  // results still owed by the receiver, oldest first
	int   bytes_sent = 0;
	int   payloads_seen = 0;
	int   statuses_seen = 0;
	int   errors = 0;
	int   cycles = 0;
	bit   tx_gaps = 1'b1;
	bit   rx_gaps = 1'b1;
	int   pop_hold = 0;

	crc32c_frame_receiver dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.out_kind    (out_kind),
		.payload_byte(payload_byte),
		.frame_status(frame_status),
		.cfg_wr      (cfg_wr),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Reflected CRC-32C, one bit at a time
	function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	// Advance the shadow by one accepted byte; return 1 when it yields a result
	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		r = '0;
		case (rx_phase)
		IN_PAYLOAD: begin
			crc_acc = crc_update(crc_acc, b);
			pos_cnt++;
			if (pos_cnt >= length_acc) begin
				rx_phase = IN_CRC;
				pos_cnt = 0;
			end
			r.out_kind = KIND_PAYLOAD;
			r.payload_byte = b;
			return 1'b1;
		end
		IN_CRC: begin
			crc_rx = {crc_rx[23:0], b};
			pos_cnt++;
			if (pos_cnt < CRC_BYTES)
				return 1'b0;
			rx_phase = HUNT_HEADER;
			pos_cnt = 0;
			r.out_kind = KIND_STATUS;
			r.frame_status = (~crc_acc == crc_rx) ? ST_OK : ST_CRC_MISM;
			return 1'b1;
		end
		default: ;
		endcase

		// header hunting
		if (pos_cnt >= HDR_BYTES)
			pos_cnt = 0;
		if (pos_cnt < 4)
			magic_acc = {magic_acc[23:0], b};
		else if (pos_cnt == 4)
			version_acc = b;
		else
			length_acc = {length_acc[23:0], b};
		pos_cnt++;
		if (pos_cnt < HDR_BYTES)
			return 1'b0;

		// header complete: magic, then version, then length
		pos_cnt = 0;
		r.out_kind = KIND_STATUS;
		if (magic_acc != want_magic) begin
			r.frame_status = ST_BAD_MAGIC;
			return 1'b1;
		end
		if (version_acc != want_version) begin
			r.frame_status = ST_BAD_VERSION;
			return 1'b1;
		end
		if (length_acc > len_limit) begin
			r.frame_status = ST_OVERSIZED;
			return 1'b1;
		end
		crc_acc = CRC_INIT;
		crc_rx = 32'd0;
		rx_phase = (length_acc == 0) ? IN_CRC : IN_PAYLOAD;
		return 1'b0;
	endfunction

	// Offer one byte, hold it until taken, then log what it owes.
	// Entered and left at a falling edge.
	task automatic send_byte(input logic [7:0] b, input bit typed, input res_t typed_res);
		res_t r;
		bit   has;
		if (tx_gaps && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		has = deframe_byte(b, r);
		if (typed)
			awaited.push_back(typed_res);
		else if (has)
			awaited.push_back(r);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Build one random frame or broken header and send it
	task automatic drive_frame();
		logic [7:0]  stream[$];
		logic [31:0] magic;
		logic [31:0] len;
		logic [31:0] crc;
		logic [31:0] mask;
		logic [7:0]  ver;
		int          pick;
		int          n;
		pick = $urandom_range(0, 99);
		magic = want_magic;
		ver = want_version;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
		len = (n > len_limit) ? len_limit : n;
		mask = $urandom;
		if (mask == 0)
			mask = 32'd1;
		// no length can exceed an all-ones limit; break the version instead
		if (pick >= 81 && pick <= 88 && len_limit == 32'hFFFF_FFFF)
			pick = 75;

		if (pick >= 89) begin
			// line noise shaped as a header; keep its magic from matching
			repeat (HDR_BYTES) stream.push_back(8'($urandom));
			if ({stream[0], stream[1], stream[2], stream[3]} == want_magic)
				stream[0] = ~stream[0];
		end else begin
			if (pick >= 65 && pick <= 72)
				magic = magic ^ mask;
			else if (pick >= 73 && pick <= 80)
				ver = ver ^ 8'($urandom_range(1, 255));
			else if (pick >= 81)
				len = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF :
					len_limit + 32'd1 + ($urandom % (32'hFFFF_FFFF - len_limit));
			stream = '{magic[31:24], magic[23:16], magic[15:8], magic[7:0], ver,
				len[31:24], len[23:16], len[15:8], len[7:0]};
			if (pick < 65) begin
				crc = CRC_INIT;
				repeat (len) begin
					stream.push_back(8'($urandom));
					crc = crc_update(crc, stream[$]);
				end
				crc = ~crc;
				if (pick >= 55)
					crc = crc ^ mask;
				stream.push_back(crc[31:24]);
				stream.push_back(crc[23:16]);
				stream.push_back(crc[15:8]);
				stream.push_back(crc[7:0]);
			end
		end
		foreach (stream[i])
			send_byte(stream[i], 1'b0, '0);
	endtask

	// Write all registers back to back; optionally poke the unused index too
	task automatic write_config(input logic [31:0] magic, input logic [7:0] ver,
			input logic [31:0] lim, input bit touch_unused);
		cfg_wr <= 1'b1;
		cfg_addr <= REG_MAGIC;
		cfg_wdata <= magic;
		@(negedge clk);
		// junk above bit 7 must be dropped by the 8-bit register
		cfg_addr <= REG_VERSION;
		cfg_wdata <= {24'($urandom), ver};
		@(negedge clk);
		cfg_addr <= REG_MAX_LEN;
		cfg_wdata <= lim;
		@(negedge clk);
		if (touch_unused) begin
			cfg_addr <= REG_UNUSED;
			cfg_wdata <= $urandom;
			@(negedge clk);
		end
		cfg_wr <= 1'b0;
		want_magic = magic;
		want_version = ver;
		len_limit = lim;
	endtask

	// Drain: wait for every owed result, then let the pipeline empty
	task automatic settle();
		push <= 1'b0;
		while (awaited.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Consumer: pop with random stall bursts while rx_gaps is set
	always @(negedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(1, 6) - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare each popped result with the oldest owed one
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (out_kind == KIND_STATUS)
				statuses_seen++;
			else
				payloads_seen++;
			if (awaited.size() == 0) begin
				$error("result with none owed: out_kind %0d payload_byte %02h frame_status %0d",
					out_kind, payload_byte, frame_status);
				errors++;
			end else begin
				want = awaited.pop_front();
				if (out_kind !== want.out_kind) begin
					$error("out_kind: expected %0d, got %0d", want.out_kind, out_kind);
					errors++;
				end
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %02h, got %02h",
						want.payload_byte, payload_byte);
					errors++;
				end
				if (frame_status !== want.frame_status) begin
					$error("frame_status: expected %0d, got %0d",
						want.frame_status, frame_status);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, awaited.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows under reset config
		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed,
				'{out_kind: KIND_STATUS, payload_byte: 8'h00,
				frame_status: DIRECTED_ROWS[i].status});
		settle();

		// High extremes: any length is in range
		write_config(32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		while (bytes_sent < 300) drive_frame();
		settle();

		// Low extremes: only zero-length frames pass
		write_config(32'h0000_0000, 8'h00, 32'h0000_0000, 1'b0);
		while (bytes_sent < 450) drive_frame();
		settle();

		// Random words with a tight length limit
		write_config($urandom, 8'($urandom), $urandom_range(1, 40), 1'b0);
		while (bytes_sent < 800) drive_frame();
		settle();

		// Last stretch runs back to back on both sides
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		write_config($urandom, 8'($urandom), 32'd64, 1'b0);
		while (bytes_sent < 1050) drive_frame();
		settle();

		$display("Sent %0d stream bytes across four register settings plus reset defaults;",
			bytes_sent);
		$display("checked %0d forwarded payload bytes and %0d frame statuses.",
			payloads_seen, statuses_seen);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
